// ===== design/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = 5;
  localparam int POOL_BLOCKS = 128;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RETAIN  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_NALLOC = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_UPDATE,
    S_DONE
  } bba_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] block_index;
  } bba_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] granted_block;
    logic       block_freed;
    logic [7:0] blocks_in_use;
    logic [7:0] peak_in_use;
  } bba_out_t;

  // highest set bit, binary search over halves
  function automatic logic [BIT_W-1:0] bba_top_bit(input logic [WORD_BITS-1:0] w);
    logic [15:0]      h;
    logic [7:0]       q;
    logic [3:0]       e;
    logic [1:0]       t;
    logic [BIT_W-1:0] r;
    r[4] = |w[31:16];
    h    = r[4] ? w[31:16] : w[15:0];
    r[3] = |h[15:8];
    q    = r[3] ? h[15:8] : h[7:0];
    r[2] = |q[7:4];
    e    = r[2] ? q[7:4] : q[3:0];
    r[1] = |e[3:2];
    t    = r[1] ? e[3:2] : e[1:0];
    r[0] = t[1];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/bba_refcnt_ram.sv =====
`default_nettype none
module bba_refcnt_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/bba_bitmap.sv =====
`default_nettype none
module bba_bitmap
  import bba_pkg::*;
#(
  parameter int POOL_BLOCKS = 128,
  parameter int NUM_WORDS   = 4,
  parameter int WI          = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [WI-1:0]        idx,
  input  wire logic                 set_en,
  input  wire logic                 clr_en,
  input  wire logic [BIT_W-1:0]     bit_idx,
  output logic      [WORD_BITS-1:0] word,
  output logic                      word_nz,
  output logic      [BIT_W-1:0]     top_bit
);

  logic [WORD_BITS-1:0] bitmap_r [NUM_WORDS];
  logic [WORD_BITS-1:0] mask;

  function automatic logic [WORD_BITS-1:0] reset_word(input int w);
    logic [WORD_BITS-1:0] r;
    for (int b = 0; b < WORD_BITS; b++) begin
      r[b] = (w * WORD_BITS + b) < POOL_BLOCKS;
    end
    return r;
  endfunction

  assign word    = bitmap_r[idx];
  assign word_nz = |word;
  assign top_bit = bba_top_bit(word);
  assign mask    = WORD_BITS'(1) << bit_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        bitmap_r[w] <= reset_word(w);
      end
    end else if (set_en) begin
      bitmap_r[idx] <= word | mask;
    end else if (clr_en) begin
      bitmap_r[idx] <= word & ~mask;
    end
  end

endmodule
`default_nettype wire

// ===== design/bitmap_block_allocator_refcount_core.sv =====
`default_nettype none
// Block allocator with per-block reference counts.
// Input channel (in_valid/in_ready/in_data) takes one word per operation:
// allocate, release or retain. Result channel (out_valid/out_ready/out_data)
// returns exactly one word per operation, in order.
// in_ready is high only while the sequencer is idle; one operation is worked
// at a time. Allocate scans the free bitmap one 32-bit word per cycle from
// the hint word. Release and retain check the bitmap (a block that is not
// allocated is answered as such), then read the reference count RAM
// (registered read) and write back the changed count; a release of the last
// reference frees the block instead. Other opcodes answer ok.
// The result sits in an output register; while the receiver stalls the
// block still takes the next operation and finishes it, then holds in its
// final step until the output register frees up.
// Reset (synchronous, rst_n low) marks every block free, clears the hint,
// in-use and peak counts, and empties the output register. Reference counts
// are not cleared; a count is written on allocate before it is ever read.
module bitmap_block_allocator_refcount_core
  import bba_pkg::*;
#(
  parameter int REF_COUNT_BITS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bba_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bba_out_t      out_data
);

  localparam int NUM_WORDS = (POOL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WI        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int HW        = $clog2(NUM_WORDS + 1);
  localparam int BW        = $clog2(POOL_BLOCKS);
  localparam int CW        = $clog2(POOL_BLOCKS + 1);
  localparam int RW        = REF_COUNT_BITS;
  localparam logic [RW-1:0] REF_MAX = '1;

  bba_state_t      state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [6:0]      blk_r, blk_nxt;
  logic [HW-1:0]   ptr_r, ptr_nxt;
  logic [HW-1:0]   hint_r, hint_nxt;
  logic [CW-1:0]   in_use_r, in_use_nxt;
  logic [CW-1:0]   peak_r, peak_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [6:0]      granted_r, granted_nxt;
  logic            freed_r, freed_nxt;
  logic            out_valid_r, out_valid_nxt;
  bba_out_t        out_data_r, out_data_nxt;

  logic [WI-1:0]        bm_idx;
  logic                 bm_set, bm_clr;
  logic [BIT_W-1:0]     bm_bit;
  logic [WORD_BITS-1:0] bm_word;
  logic                 bm_nz;
  logic [BIT_W-1:0]     bm_top;

  logic          ram_we;
  logic [BW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic                 out_load;
  logic                 blk_in_pool;
  logic [WI-1:0]        blk_w;
  logic [WI+BIT_W-1:0]  num;
  logic [WORD_BITS-1:0] word_left;
  logic [CW-1:0]        in_use_inc;

  bba_bitmap #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .NUM_WORDS  (NUM_WORDS),
    .WI         (WI)
  ) u_bitmap (
    .clk    (clk),
    .rst_n  (rst_n),
    .idx    (bm_idx),
    .set_en (bm_set),
    .clr_en (bm_clr),
    .bit_idx(bm_bit),
    .word   (bm_word),
    .word_nz(bm_nz),
    .top_bit(bm_top)
  );

  bba_refcnt_ram #(
    .DEPTH(POOL_BLOCKS),
    .WIDTH(RW)
  ) u_refcnt (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(BW'(blk_r)),
    .rdata(ram_rdata)
  );

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign blk_in_pool = 32'(blk_r) < 32'(POOL_BLOCKS);
  assign blk_w       = WI'(blk_r[6:5]);
  assign num         = {ptr_r[WI-1:0], bm_top};
  assign word_left   = bm_word & ~(WORD_BITS'(1) << bm_top);
  assign in_use_inc  = in_use_r + 1'b1;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hint_r      <= '0;
      in_use_r    <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      in_use_r    <= in_use_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    blk_r      <= blk_nxt;
    ptr_r      <= ptr_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    freed_r    <= freed_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    blk_nxt       = blk_r;
    ptr_nxt       = ptr_r;
    hint_nxt      = hint_r;
    in_use_nxt    = in_use_r;
    peak_nxt      = peak_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    freed_nxt     = freed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    bm_idx        = ptr_r[WI-1:0];
    bm_set        = 1'b0;
    bm_clr        = 1'b0;
    bm_bit        = bm_top;
    ram_we        = 1'b0;
    ram_waddr     = BW'(num);
    ram_wdata     = RW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.opcode;
          blk_nxt     = in_data.block_index;
          ptr_nxt     = hint_r;
          status_nxt  = ST_OK;
          granted_nxt = '0;
          freed_nxt   = 1'b0;
          unique case (in_data.opcode)
            OP_ALLOC:   state_nxt = S_SCAN;
            OP_RELEASE: state_nxt = S_CHECK;
            OP_RETAIN:  state_nxt = S_CHECK;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_r >= HW'(NUM_WORDS)) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else if (bm_nz) begin
          bm_clr      = 1'b1;
          ram_we      = 1'b1;
          granted_nxt = 7'(num);
          hint_nxt    = (word_left == '0) ? ptr_r + 1'b1 : ptr_r;
          in_use_nxt  = in_use_inc;
          if (in_use_inc > peak_r) begin
            peak_nxt = in_use_inc;
          end
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_CHECK: begin
        bm_idx = blk_w;
        if (!blk_in_pool || bm_word[blk_r[4:0]]) begin
          status_nxt = ST_NALLOC;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        bm_idx    = blk_w;
        bm_bit    = blk_r[4:0];
        ram_waddr = BW'(blk_r);
        if (op_r == OP_RETAIN) begin
          ram_we    = (ram_rdata != REF_MAX);
          ram_wdata = ram_rdata + 1'b1;
        end else if (ram_rdata > RW'(1)) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata - 1'b1;
        end else begin
          bm_set    = 1'b1;
          freed_nxt = 1'b1;
          if (HW'(blk_w) < hint_r) begin
            hint_nxt = HW'(blk_w);
          end
          if (in_use_r != '0) begin
            in_use_nxt = in_use_r - 1'b1;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.granted_block = granted_r;
          out_data_nxt.block_freed   = freed_r;
          out_data_nxt.blocks_in_use = 8'(in_use_r);
          out_data_nxt.peak_in_use   = 8'(peak_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(in_use_r) <= 32'(POOL_BLOCKS))
    else $error("in-use count above pool size");

  a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= in_use_r)
    else $error("peak below in-use count");

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hint_r) <= 32'(NUM_WORDS))
    else $error("hint beyond bitmap");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while one is in flight");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid)
    else $error("result load lost");

endmodule
`default_nettype wire
